[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/dec_pkg.sv]
`timescale 1ns / 1ps

package dec_pkg;

    localparam int OUT_WIDTH       = 32;
    localparam int NUM_CH          = 2;
    localparam int EDGE_WIDTH      = 2;
    localparam int DEB_WIDTH       = 8;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 8;

    localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = 8'd100;
    localparam logic [NUM_CH-1:0]    DIR_RESET      = 2'b11;

    typedef enum logic [EDGE_WIDTH-1:0] {
        EDGE_RISING  = 2'd0,
        EDGE_FALLING = 2'd1,
        EDGE_BOTH    = 2'd2
    } edge_kind_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_EDGE_A   = 3'd0,
        REG_EDGE_B   = 3'd1,
        REG_DEB_A    = 3'd2,
        REG_DEB_B    = 3'd3,
        REG_DIR_MASK = 3'd4
    } cfg_reg_t;

    function automatic logic edge_match(input logic [EDGE_WIDTH-1:0] kind, input logic level);
        logic hit;
        unique case (kind)
            EDGE_RISING:  hit = level;
            EDGE_FALLING: hit = !level;
            EDGE_BOTH:    hit = 1'b1;
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

[hdl/debounced_edge_counter.sv]
`timescale 1ns / 1ps
// A result is registered, valid in the cycle after its request is accepted. Throughput:
// one request per cycle while out_ready is high; output frees in the cycle it is taken.
// Reset (rst_n low, asynchronous): counts and hold-off clear, stored levels go high,
// the arm flag drops, edge kinds go to rising, debounce to 100, both channels to input.
module debounced_edge_counter #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dec_pkg::NUM_CH-1:0]            pin_levels,
    input  logic                                  int_active,
    input  logic [dec_pkg::NUM_CH-1:0]            clear_count,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [dec_pkg::OUT_WIDTH-1:0]         count_a,
    output logic [dec_pkg::OUT_WIDTH-1:0]         count_b,
    input  logic                                  cfg_we,
    input  logic [dec_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [dec_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int NCH  = dec_pkg::NUM_CH;
    localparam int OW   = dec_pkg::OUT_WIDTH;
    localparam int DW   = dec_pkg::DEB_WIDTH;
    localparam int EW   = dec_pkg::EDGE_WIDTH;

    logic [EW-1:0]          edge_type_reg [NCH];
    logic [EW-1:0]          edge_type_next [NCH];
    logic [DW-1:0]          debounce_reg [NCH];
    logic [DW-1:0]          debounce_next [NCH];
    logic [NCH-1:0]         dir_reg;
    logic [NCH-1:0]         dir_next;
    logic [DW-1:0]          hold_reg [NCH];
    logic [DW-1:0]          hold_next [NCH];
    logic [NCH-1:0]         last_reg;
    logic [NCH-1:0]         last_next;
    logic [COUNT_WIDTH-1:0] total_reg [NCH];
    logic [COUNT_WIDTH-1:0] total_next [NCH];
    logic [COUNT_WIDTH-1:0] total_step [NCH];
    logic                   armed_reg;
    logic                   armed_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OW-1:0]          count_a_reg;
    logic [OW-1:0]          count_b_reg;
    logic [OW-1:0]          count_a_next;
    logic [OW-1:0]          count_b_next;
    logic [OW+COUNT_WIDTH-1:0] ext_a;
    logic [OW+COUNT_WIDTH-1:0] ext_b;
    logic                   accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign count_a   = count_a_reg;
    assign count_b   = count_b_reg;

    always_comb
    begin
        logic [DW-1:0] hold_dec;
        hold_dec       = '0;
        armed_next     = armed_reg;
        dir_next       = dir_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        for (int ch = 0; ch < NCH; ch++)
        begin
            edge_type_next[ch] = edge_type_reg[ch];
            debounce_next[ch]  = debounce_reg[ch];
            hold_next[ch]      = hold_reg[ch];
            total_next[ch]     = total_reg[ch];
            total_step[ch]     = total_reg[ch];
        end

        if (accept)
        begin
            armed_next     = armed_reg || int_active;
            out_valid_next = 1'b1;
            for (int ch = 0; ch < NCH; ch++)
            begin
                hold_dec = (hold_reg[ch] != '0) ? hold_reg[ch] - DW'(1) : hold_reg[ch];
                hold_next[ch] = hold_dec;
                if (armed_next && hold_dec == '0 && dir_reg[ch] &&
                    pin_levels[ch] != last_reg[ch])
                begin
                    last_next[ch] = pin_levels[ch];
                    hold_next[ch] = debounce_reg[ch];
                    if (dec_pkg::edge_match(edge_type_reg[ch], pin_levels[ch]))
                    begin
                        total_step[ch] = total_reg[ch] + COUNT_WIDTH'(1);
                    end
                end
                total_next[ch] = clear_count[ch] ? '0 : total_step[ch];
            end
        end

        if (cfg_we)
        begin
            unique case (dec_pkg::cfg_reg_t'(cfg_index))
                dec_pkg::REG_EDGE_A:
                begin
                    edge_type_next[0] = cfg_data[EW-1:0];
                    total_next[0]     = '0;
                end
                dec_pkg::REG_EDGE_B:
                begin
                    edge_type_next[1] = cfg_data[EW-1:0];
                    total_next[1]     = '0;
                end
                dec_pkg::REG_DEB_A:
                begin
                    debounce_next[0] = cfg_data[DW-1:0];
                    total_next[0]    = '0;
                end
                dec_pkg::REG_DEB_B:
                begin
                    debounce_next[1] = cfg_data[DW-1:0];
                    total_next[1]    = '0;
                end
                dec_pkg::REG_DIR_MASK:
                begin
                    dir_next = cfg_data[NCH-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ext_a = {{OW{1'b0}}, total_step[0]};
    assign ext_b = {{OW{1'b0}}, total_step[1]};

    always_comb
    begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (accept)
        begin
            count_a_next = ext_a[OW-1:0];
            count_b_next = ext_b[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            dir_reg       <= dec_pkg::DIR_RESET;
            last_reg      <= '1;
            out_valid_reg <= 1'b0;
            for (int ch = 0; ch < NCH; ch++)
            begin
                edge_type_reg[ch] <= dec_pkg::EDGE_RISING;
                debounce_reg[ch]  <= dec_pkg::DEBOUNCE_RESET;
                hold_reg[ch]      <= '0;
                total_reg[ch]     <= '0;
            end
        end
        else
        begin
            armed_reg     <= armed_next;
            dir_reg       <= dir_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            for (int ch = 0; ch < NCH; ch++)
            begin
                edge_type_reg[ch] <= edge_type_next[ch];
                debounce_reg[ch]  <= debounce_next[ch];
                hold_reg[ch]      <= hold_next[ch];
                total_reg[ch]     <= total_next[ch];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_a_reg <= count_a_next;
        count_b_reg <= count_b_next;
    end

endmodule

[hdl/dec_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dec_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dec_pkg::OUT_WIDTH-1:0] count_a,
    input logic [dec_pkg::OUT_WIDTH-1:0] count_b
);

    `ASSERT_ALWAYS(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(count_a) && $stable(count_b), "result changed while stalled")
    `ASSERT_ALWAYS(a_request_to_result, in_valid && in_ready |=> out_valid, "accepted request gave no result")
    `ASSERT_NEVER(a_ready_when_empty, !out_valid && !in_ready, "not ready with empty output")
    `ASSERT_ALWAYS(a_no_spurious_result, !out_valid && !(in_valid && in_ready) |=> !out_valid, "result without request")

endmodule

bind debounced_edge_counter dec_checker u_dec_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    typedef logic [dec_pkg::NUM_CH-1:0]          ch_bits_t;
    typedef logic [dec_pkg::EDGE_WIDTH-1:0]      edge_bits_t;
    typedef logic [dec_pkg::DEB_WIDTH-1:0]       deb_bits_t;
    typedef logic [dec_pkg::OUT_WIDTH-1:0]       count_bits_t;
    typedef logic [dec_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [dec_pkg::CFG_DATA_WIDTH-1:0]  cfg_bits_t;

    localparam edge_bits_t EDGE_NONE    = 2'd3;
    localparam cfg_index_t REG_SPARE_LO = 3'd5;
    localparam cfg_index_t REG_SPARE_HI = 3'd7;
    localparam int         LONG_HOLD    = 60;

    class edge_count_scoreboard;
        edge_bits_t  kind [dec_pkg::NUM_CH];
        deb_bits_t   deb [dec_pkg::NUM_CH];
        ch_bits_t    dir_mask;
        deb_bits_t   hold [dec_pkg::NUM_CH];
        logic        lvl [dec_pkg::NUM_CH];
        count_bits_t total [dec_pkg::NUM_CH];
        logic        armed;
        count_bits_t want_a [$];
        count_bits_t want_b [$];
        int          errors;

        function new();
            for (int ch = 0; ch < dec_pkg::NUM_CH; ch++)
            begin
                kind[ch]  = dec_pkg::EDGE_RISING;
                deb[ch]   = dec_pkg::DEBOUNCE_RESET;
                hold[ch]  = '0;
                lvl[ch]   = 1'b1;
                total[ch] = '0;
            end
            dir_mask = dec_pkg::DIR_RESET;
            armed    = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(cfg_index_t idx, cfg_bits_t data);
            case (idx)
                dec_pkg::REG_EDGE_A:
                begin
                    kind[0]  = data[dec_pkg::EDGE_WIDTH-1:0];
                    total[0] = '0;
                end
                dec_pkg::REG_EDGE_B:
                begin
                    kind[1]  = data[dec_pkg::EDGE_WIDTH-1:0];
                    total[1] = '0;
                end
                dec_pkg::REG_DEB_A:
                begin
                    deb[0]   = data[dec_pkg::DEB_WIDTH-1:0];
                    total[0] = '0;
                end
                dec_pkg::REG_DEB_B:
                begin
                    deb[1]   = data[dec_pkg::DEB_WIDTH-1:0];
                    total[1] = '0;
                end
                dec_pkg::REG_DIR_MASK: dir_mask = data[dec_pkg::NUM_CH-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(ch_bits_t pins, logic intr, ch_bits_t clr);
            logic hit;
            for (int ch = 0; ch < dec_pkg::NUM_CH; ch++)
                if (hold[ch] != '0)
                    hold[ch] = hold[ch] - deb_bits_t'(1);
            if (intr)
                armed = 1'b1;
            if (armed)
            begin
                for (int ch = 0; ch < dec_pkg::NUM_CH; ch++)
                begin
                    if (hold[ch] == '0 && dir_mask[ch] && pins[ch] != lvl[ch])
                    begin
                        lvl[ch]  = pins[ch];
                        hold[ch] = deb[ch];
                        case (kind[ch])
                            dec_pkg::EDGE_RISING:  hit = pins[ch];
                            dec_pkg::EDGE_FALLING: hit = !pins[ch];
                            dec_pkg::EDGE_BOTH:    hit = 1'b1;
                            default:               hit = 1'b0;
                        endcase
                        if (hit)
                            total[ch] = total[ch] + count_bits_t'(1);
                    end
                end
            end
            want_a.push_back(total[0]);
            want_b.push_back(total[1]);
            for (int ch = 0; ch < dec_pkg::NUM_CH; ch++)
                if (clr[ch])
                    total[ch] = '0;
        endfunction

        function void check_result(count_bits_t a, count_bits_t b);
            count_bits_t ea;
            count_bits_t eb;
            if (want_a.size() == 0)
            begin
                $display("%0t: unexpected result count_a=%0d count_b=%0d", $time, a, b);
                errors++;
            end
            else
            begin
                ea = want_a.pop_front();
                eb = want_b.pop_front();
                if (a !== ea)
                begin
                    $display("%0t: count_a expected %0d actual %0d", $time, ea, a);
                    errors++;
                end
                if (b !== eb)
                begin
                    $display("%0t: count_b expected %0d actual %0d", $time, eb, b);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return want_a.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    ch_bits_t    pin_levels;
    logic        int_active;
    ch_bits_t    clear_count;
    logic        out_valid;
    logic        out_ready;
    count_bits_t count_a;
    count_bits_t count_b;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    cfg_bits_t   cfg_data;

    edge_count_scoreboard sb;
    bit                   tx_steady;
    bit                   hold_request;
    ch_bits_t             pin_state;

    debounced_edge_counter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pin_levels  (pin_levels),
        .int_active  (int_active),
        .clear_count (clear_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .count_a     (count_a),
        .count_b     (count_b),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(count_a, count_b);
            if (in_valid && in_ready)
                sb.note_request(pin_levels, int_active, clear_count);
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // receiver: bursts of ready, short stalls, rare long stalls, one forced hold-off
    initial
    begin
        int r;
        out_ready <= 1'b0;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
                else if (r < 95)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    task automatic send_tick(input ch_bits_t pins, input logic intr, input ch_bits_t clr);
        int gap;
        int r;
        in_valid    <= 1'b1;
        pin_levels  <= pins;
        int_active  <= intr;
        clear_count <= clr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_put(input cfg_index_t idx, input cfg_bits_t value,
                           input cfg_bits_t used);
        cfg_bits_t noise;
        noise = cfg_bits_t'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (value & used) | (noise & ~used);
        @(posedge clk);
    endtask

    task automatic set_config(input edge_bits_t ea, input edge_bits_t eb,
                              input deb_bits_t da, input deb_bits_t db,
                              input ch_bits_t dir, input bit spare);
        drain();
        cfg_put(dec_pkg::REG_EDGE_A, cfg_bits_t'(ea), 8'h03);
        cfg_put(dec_pkg::REG_EDGE_B, cfg_bits_t'(eb), 8'h03);
        cfg_put(dec_pkg::REG_DEB_A, da, 8'hFF);
        cfg_put(dec_pkg::REG_DEB_B, db, 8'hFF);
        cfg_put(dec_pkg::REG_DIR_MASK, cfg_bits_t'(dir), 8'h03);
        if (spare)
        begin
            cfg_put(REG_SPARE_LO, 8'h00, 8'h00);
            cfg_put(REG_SPARE_HI, 8'h00, 8'h00);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_ticks(input int n);
        ch_bits_t clr;
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 49)
                tx_steady = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) < 35)
                pin_state = ch_bits_t'($urandom_range(0, 3));
            clr = ($urandom_range(0, 15) == 0) ? ch_bits_t'($urandom_range(0, 3)) : '0;
            send_tick(pin_state, $urandom_range(0, 9) == 0, clr);
        end
    endtask

    initial
    begin
        sb           = new();
        tx_steady    = 1'b0;
        hold_request = 1'b0;
        pin_state    = '0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        pin_levels  <= '0;
        int_active  <= 1'b0;
        clear_count <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unarmed changes, then arm under the reset debounce
        send_tick(2'b00, 1'b0, 2'b00);
        send_tick(2'b11, 1'b0, 2'b00);
        send_tick(2'b00, 1'b1, 2'b00);
        send_tick(2'b11, 1'b0, 2'b00);

        set_config(dec_pkg::EDGE_RISING, dec_pkg::EDGE_FALLING, 8'd0, 8'd0, 2'b11, 1'b0);
        send_tick(2'b11, 1'b0, 2'b00);
        send_tick(2'b00, 1'b0, 2'b00);
        send_tick(2'b11, 1'b0, 2'b00);
        send_tick(2'b00, 1'b0, 2'b00);
        send_tick(2'b11, 1'b0, 2'b01);
        send_tick(2'b00, 1'b0, 2'b10);
        send_tick(2'b11, 1'b1, 2'b11);

        // edge kind three on b, b as output, unused register indexes
        set_config(dec_pkg::EDGE_BOTH, EDGE_NONE, 8'd2, 8'd255, 2'b01, 1'b1);
        send_tick(2'b00, 1'b0, 2'b00);
        send_tick(2'b11, 1'b0, 2'b00);
        send_tick(2'b00, 1'b0, 2'b00);
        send_tick(2'b11, 1'b0, 2'b00);
        send_tick(2'b10, 1'b0, 2'b00);

        set_config(dec_pkg::EDGE_FALLING, EDGE_NONE, 8'd1, 8'd0, 2'b10, 1'b0);
        send_tick(2'b01, 1'b0, 2'b00);
        send_tick(2'b10, 1'b0, 2'b00);
        send_tick(2'b01, 1'b0, 2'b00);
        send_tick(2'b10, 1'b0, 2'b00);

        set_config(dec_pkg::EDGE_BOTH, dec_pkg::EDGE_BOTH, 8'd0, 8'd0, 2'b00, 1'b0);
        send_tick(2'b01, 1'b0, 2'b00);
        send_tick(2'b10, 1'b1, 2'b11);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_config(dec_pkg::EDGE_RISING, dec_pkg::EDGE_FALLING,
                              8'd0, 8'd0, 2'b11, 1'b0);
                1: set_config(dec_pkg::EDGE_BOTH, dec_pkg::EDGE_BOTH,
                              8'd1, 8'd255, 2'b11, 1'b1);
                2: set_config(EDGE_NONE, dec_pkg::EDGE_BOTH, 8'd2, 8'd0, 2'b01, 1'b0);
                3: set_config(dec_pkg::EDGE_BOTH, dec_pkg::EDGE_RISING,
                              8'd0, 8'd3, 2'b11, 1'b0);
                4: set_config(dec_pkg::EDGE_FALLING, dec_pkg::EDGE_RISING,
                              8'd255, 8'd1, 2'b10, 1'b1);
                default: set_config(edge_bits_t'($urandom_range(0, 3)),
                                    edge_bits_t'($urandom_range(0, 3)),
                                    deb_bits_t'($urandom_range(0, 7)),
                                    deb_bits_t'($urandom_range(0, 7)),
                                    ch_bits_t'($urandom_range(0, 3)), 1'b1);
            endcase
            if (p == 3)
            begin
                // hold the receiver off while requests keep coming
                tx_steady    = 1'b1;
                hold_request = 1'b1;
            end
            random_ticks(190);
        end

        drain();
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
